/* src/cws_pkg.sv */
package cws_pkg;

    // Fixed field widths of the item and result beats
    localparam int VALUE_BITS     = 32;
    localparam int WEIGHT_IN_BITS = 32;
    localparam int POS_BITS       = 40;

    // Defaults for the top level parameters
    localparam int DEF_TABLE_DEPTH = 256;
    localparam int DEF_WEIGHT_BITS = 32;

    // Headroom of the running sum above the weight width
    localparam int CUM_EXTRA_BITS = 8;

    typedef enum logic [0:0] {
        OP_APPEND = 1'b0,
        OP_LOOKUP = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_DONE
    } state_t;

endpackage

/* src/cws_in_if.sv */
interface cws_in_if import cws_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic                         op;
    logic signed [VALUE_BITS-1:0] entry_value;
    logic [WEIGHT_IN_BITS-1:0]    entry_weight;
    logic [POS_BITS-1:0]          search_position;

    modport source (
        output valid, op, entry_value, entry_weight, search_position,
        input  ready
    );

    modport sink (
        input  valid, op, entry_value, entry_weight, search_position,
        output ready
    );
endinterface

/* src/cws_out_if.sv */
interface cws_out_if import cws_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] result_value;
    logic                         found;
    logic                         full_error;

    modport source (
        output valid, result_value, found, full_error,
        input  ready
    );

    modport sink (
        input  valid, result_value, found, full_error,
        output ready
    );
endinterface

/* src/cumulative_weight_selector.sv */
// Weighted index table for roulette wheel selection. An append beat (op = 0)
// stores entry_value at the next free slot together with the running sum of
// all weights so far (24.16 fixed point at the default widths, saturating at the top of the
// WEIGHT_BITS + 8 bit range); appending to a full table returns full_error.
// A lookup beat (op = 1) binary-searches the running sums for the entry whose
// interval [sum - weight, sum) holds search_position and returns its value
// with found = 1; a position at or past the total weight, or an empty table,
// returns found = 0 and a zero value. Every item gives exactly one result
// beat. One item is worked on at a time: an accepted append goes from S_IDLE
// to S_DONE, a lookup passes through S_PROBE first for its P probes, where
// P is at most ceil(log2(entries + 1)), so 9 for a full table of 256, and
// S_DONE moves the result into the output register once it is free. The
// input is ready only in S_IDLE. The probes go through the single table RAM,
// one read per probe, and the read data is registered.
// A new item is taken while the previous result still waits in the output
// register; the one after that waits until the output register is free.
// The table needs no clearing after reset: only slots below the fill count
// are ever compared.
module cumulative_weight_selector import cws_pkg::*; #(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
    input  logic      clk,
    input  logic      rst_n,
    cws_in_if.sink    item,
    cws_out_if.source result
);

    localparam int CUM_BITS  = WEIGHT_BITS + CUM_EXTRA_BITS;
    localparam int IDX_BITS  = $clog2(TABLE_DEPTH);
    localparam int CNT_BITS  = $clog2(TABLE_DEPTH + 1);
    localparam int WORD_BITS = VALUE_BITS + 2 * CUM_BITS;
    localparam logic [CNT_BITS-1:0] DEPTH_CNT = CNT_BITS'(TABLE_DEPTH);

    // Control state
    state_t              state_reg, state_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic [CUM_BITS-1:0] last_cum_reg, last_cum_next;
    logic                out_valid_reg, out_valid_next;

    // Search and result payload
    logic [CUM_BITS-1:0]         pos_reg, pos_next;
    logic [CNT_BITS-1:0]         lo_reg, lo_next;
    logic [CNT_BITS-1:0]         hi_reg, hi_next;   // exclusive upper bound
    logic [IDX_BITS-1:0]         mid_reg, mid_next;
    logic signed [VALUE_BITS-1:0] res_value_reg, res_value_next;
    logic                        res_found_reg, res_found_next;
    logic                        res_full_reg, res_full_next;
    logic signed [VALUE_BITS-1:0] out_value_reg, out_value_next;
    logic                        out_found_reg, out_found_next;
    logic                        out_full_reg, out_full_next;

    // RAM port
    logic                 ram_we;
    logic [IDX_BITS-1:0]  ram_addr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [WORD_BITS-1:0] ram_rdata;

    // Datapath terms
    logic                 accept;
    logic                 is_lookup;
    logic                 table_full;
    logic                 out_free;
    logic [63:0]          weight_wide;
    logic [63:0]          pos_wide;
    logic [WEIGHT_BITS-1:0] weight_in;
    logic [CUM_BITS-1:0]  weight_ext;
    logic [CUM_BITS:0]    sum_wide;
    logic [CUM_BITS-1:0]  sum_sat;
    logic [CUM_BITS-1:0]  start_new;
    logic [CUM_BITS-1:0]  pos_in;

    logic signed [VALUE_BITS-1:0] rd_value;
    logic [CUM_BITS-1:0]  rd_start;
    logic [CUM_BITS-1:0]  rd_cum;
    logic                 hit;
    logic                 go_low;
    logic [CNT_BITS-1:0]  mid_ext;
    logic [CNT_BITS-1:0]  sel_lo;
    logic [CNT_BITS-1:0]  sel_hi;
    logic                 span_ok;
    logic [CNT_BITS-1:0]  mid_cnt;

    // Table word: value, interval start, running sum
    cws_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign accept     = item.valid && item.ready;
    assign is_lookup  = (item.op == OP_LOOKUP);
    assign table_full = (count_reg == DEPTH_CNT);
    assign out_free   = !out_valid_reg || result.ready;

    // Weight and position trimmed to the configured widths
    assign weight_wide = {32'b0, item.entry_weight};
    assign weight_in   = weight_wide[WEIGHT_BITS-1:0];
    assign weight_ext  = {{CUM_EXTRA_BITS{1'b0}}, weight_in};
    assign pos_wide    = {24'b0, item.search_position};
    assign pos_in      = pos_wide[CUM_BITS-1:0];

    // Saturating running sum; start of the new interval
    assign sum_wide  = {1'b0, last_cum_reg} + {1'b0, weight_ext};
    assign sum_sat   = sum_wide[CUM_BITS] ? {CUM_BITS{1'b1}} : sum_wide[CUM_BITS-1:0];
    assign start_new = sum_sat - weight_ext;

    // Probe compare on the word read for mid_reg
    assign rd_value = ram_rdata[WORD_BITS-1 -: VALUE_BITS];
    assign rd_start = ram_rdata[2*CUM_BITS-1 -: CUM_BITS];
    assign rd_cum   = ram_rdata[CUM_BITS-1:0];
    assign hit      = (rd_start <= pos_reg) && (rd_cum > pos_reg);
    assign go_low   = (rd_cum > pos_reg);
    assign mid_ext  = CNT_BITS'(mid_reg);

    // Search window for the next probe: whole table on entry, halved after
    always_comb
    begin
        if (state_reg == S_PROBE)
        begin
            sel_lo = go_low ? lo_reg : mid_ext + 1'b1;
            sel_hi = go_low ? mid_ext : hi_reg;
        end
        else
        begin
            sel_lo = '0;
            sel_hi = count_reg;
        end
    end

    assign span_ok = (sel_lo < sel_hi);
    assign mid_cnt = sel_lo + ((sel_hi - 1'b1 - sel_lo) >> 1);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (is_lookup && span_ok) ? S_PROBE : S_DONE;
                end
            end
            S_PROBE:
            begin
                if (hit || !span_ok)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Handshake and RAM control
    always_comb
    begin
        item.ready = 1'b0;
        ram_we     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                item.ready = 1'b1;
                ram_we     = item.valid && !is_lookup && !table_full;
            end
            S_PROBE, S_DONE:
            begin
                item.ready = 1'b0;
            end
            default:
            begin
                item.ready = 1'b0;
            end
        endcase
    end

    // Append writes at the fill count, otherwise the next probe is read
    assign ram_addr  = ram_we ? count_reg[IDX_BITS-1:0] : mid_next;
    assign ram_wdata = {item.entry_value, start_new, sum_sat};

    // Datapath next values
    always_comb
    begin
        count_next     = count_reg;
        last_cum_next  = last_cum_reg;
        pos_next       = pos_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_cnt[IDX_BITS-1:0];
        res_value_next = res_value_reg;
        res_found_next = res_found_reg;
        res_full_next  = res_full_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_found_next = out_found_reg;
        out_full_next  = out_full_reg;

        if (ram_we)
        begin
            count_next    = count_reg + 1'b1;
            last_cum_next = sum_sat;
        end

        if (state_reg == S_IDLE && accept)
        begin
            pos_next       = pos_in;
            lo_next        = sel_lo;
            hi_next        = sel_hi;
            res_value_next = '0;
            res_found_next = 1'b0;
            res_full_next  = !is_lookup && table_full;
        end

        if (state_reg == S_PROBE)
        begin
            lo_next = sel_lo;
            hi_next = sel_hi;
            if (hit)
            begin
                res_value_next = rd_value;
                res_found_next = 1'b1;
            end
        end

        if (state_reg == S_DONE && out_free)
        begin
            out_valid_next = 1'b1;
            out_value_next = res_value_reg;
            out_found_next = res_found_reg;
            out_full_next  = res_full_reg;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            last_cum_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            last_cum_reg  <= last_cum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        res_value_reg <= res_value_next;
        res_found_reg <= res_found_next;
        res_full_reg  <= res_full_next;
        out_value_reg <= out_value_next;
        out_found_reg <= out_found_next;
        out_full_reg  <= out_full_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.result_value = out_value_reg;
    assign result.found        = out_found_reg;
    assign result.full_error   = out_full_reg;

endmodule

/* src/cws_ram.sv */
// Single port RAM, registered read (read before write on the same address)
module cws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/cws_checker.sv */
// Port level checks: one result per item, at most two items in flight
module cws_checker import cws_pkg::*; (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic signed [VALUE_BITS-1:0] out_value,
    input logic                         out_found,
    input logic                         out_full
);

    logic [1:0] pending_reg;
    logic [1:0] pending_next;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = in_valid && in_ready;
    assign out_beat = out_valid && out_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_beat && !out_beat)
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (out_beat && !in_beat)
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 2'd0)
        else $error("result beat without an outstanding item");

    a_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("more than two items in flight");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_found && out_full))
        else $error("hit and full flags together");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_found |-> out_value == '0)
        else $error("non-zero value on a miss");

endmodule

bind cumulative_weight_selector cws_checker u_cws_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_value (result.result_value),
    .out_found (result.found),
    .out_full  (result.full_error)
);
